/* rtl/gbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants of the bounded stack grid
// Codes, field widths, reset values and the record that the front hands to
// the back through the command queue.
// ----------------------------------------------------------------------------
package gbs_pkg;

  // default sizes for the top level parameters
  localparam int MaxGridXDef = 16;
  localparam int MaxGridYDef = 16;
  localparam int MaxDepthDef = 16;

  // fixed field widths
  localparam int ActionW     = 2;
  localparam int PosW        = 5;
  localparam int CapInW      = 5;
  localparam int ItemW       = 32;
  localparam int StatusW     = 3;
  localparam int CountOutW   = 4;
  localparam int FlagW       = 3;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 5;
  localparam int CellIdxMaxW = 16;

  // command queue depth
  localparam int QueueDepth = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFloorLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGridWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGridLength = 2'd2;

  // configuration reset values
  localparam logic [CfgDataW-1:0] FloorLimitRst = 5'd16;
  localparam logic [CfgDataW-1:0] GridWidthRst  = 5'd16;
  localparam logic [CfgDataW-1:0] GridLengthRst = 5'd16;

  // result status codes
  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StCapHigh = 3'd1;
  localparam logic [StatusW-1:0] StOutside = 3'd2;
  localparam logic [StatusW-1:0] StRepSame = 3'd3;
  localparam logic [StatusW-1:0] StRepDiff = 3'd4;
  localparam logic [StatusW-1:0] StFull    = 3'd5;
  localparam logic [StatusW-1:0] StEmpty   = 3'd6;

  // sticky load error bits
  localparam logic [FlagW-1:0] ErrBadFormat = 3'b001;
  localparam logic [FlagW-1:0] ErrCapOver   = 3'b010;
  localparam logic [FlagW-1:0] ErrGrid      = 3'b100;

  typedef enum logic [ActionW-1:0] {
    ActSetCap = 2'd0,
    ActPush   = 2'd1,
    ActPop    = 2'd2,
    ActNone   = 2'd3
  } action_e;

  // command class decided by the front
  typedef enum logic [2:0] {
    KdSet       = 3'd0,
    KdPush      = 3'd1,
    KdPop       = 3'd2,
    KdNop       = 3'd3,
    KdCapHigh   = 3'd4,
    KdOutSet    = 3'd5,
    KdOutAccess = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    BkClear = 2'd0,
    BkFetch = 2'd1,
    BkEval  = 2'd2,
    BkPop   = 2'd3
  } back_state_e;

  typedef struct packed {
    kind_e                  kind;
    logic [CellIdxMaxW-1:0] cell_ix;
    logic [CapInW-1:0]      cap;
    logic [ItemW-1:0]       item;
  } op_t;

endpackage

/* rtl/grid_of_bounded_stacks.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_of_bounded_stacks: grid of small bounded LIFO stacks
// One stack per (x, y) cell. Set-capacity commands load a cell's capacity
// once, push and pop store and return item words, and every command gives
// exactly one result beat with a status, the popped word, the cell's count
// and the sticky load error flags.
//
//   channel   direction  handshake                      payload
//   command   in         start & !busy                  action, pos_x/y, capacity, item
//   result    out        done_o, one cycle, no stall    status, item, count, flags
//   config    in         cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// a command passes through the fetch and evaluate states of the back end,
// and a pop that reads the stack memory also through the pop state; done_o
// is registered from the evaluate state (from the pop state for such a pop)
// the back end fetches the next queued command only after the last one is
// through, since each is a read-modify-write of the cell table
// after reset the cell table is cleared one cell per cycle, all MAX_GRID_X *
// MAX_GRID_Y cells (256 by default); busy stays high, config beats are taken
// busy also rises while the two-entry command queue is full; results cannot
// be held off by the receiver
// ----------------------------------------------------------------------------
module grid_of_bounded_stacks #(
  parameter int MAX_GRID_X = gbs_pkg::MaxGridXDef,
  parameter int MAX_GRID_Y = gbs_pkg::MaxGridYDef,
  parameter int MAX_DEPTH  = gbs_pkg::MaxDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command beat
  input  logic                           start,
  output logic                           busy,
  input  logic [gbs_pkg::ActionW-1:0]    action_i,
  input  logic [gbs_pkg::PosW-1:0]       pos_x_i,
  input  logic [gbs_pkg::PosW-1:0]       pos_y_i,
  input  logic [gbs_pkg::CapInW-1:0]     capacity_in_i,
  input  logic [gbs_pkg::ItemW-1:0]      item_in_i,
  // result beat
  output logic                           done_o,
  output logic [gbs_pkg::StatusW-1:0]    status_o,
  output logic [gbs_pkg::ItemW-1:0]      item_out_o,
  output logic [gbs_pkg::CountOutW-1:0]  stack_count_o,
  output logic [gbs_pkg::FlagW-1:0]      error_flags_o,
  // configuration write beat
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gbs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gbs_pkg::CfgDataW-1:0]   cfg_data_i
);

  // configuration registers
  logic [gbs_pkg::CfgDataW-1:0] floor_limit_q, floor_limit_d;
  logic [gbs_pkg::CfgDataW-1:0] grid_width_q, grid_width_d;
  logic [gbs_pkg::CfgDataW-1:0] grid_length_q, grid_length_d;

  // front to queue to back
  gbs_pkg::op_t op_in, op_head;
  logic         q_push, q_pop, q_empty, q_full, clearing;

  // config beats are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    floor_limit_d = floor_limit_q;
    grid_width_d  = grid_width_q;
    grid_length_d = grid_length_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gbs_pkg::RegFloorLimit: floor_limit_d = cfg_data_i;
        gbs_pkg::RegGridWidth:  grid_width_d  = cfg_data_i;
        gbs_pkg::RegGridLength: grid_length_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_limit_q <= gbs_pkg::FloorLimitRst;
      grid_width_q  <= gbs_pkg::GridWidthRst;
      grid_length_q <= gbs_pkg::GridLengthRst;
    end else begin
      floor_limit_q <= floor_limit_d;
      grid_width_q  <= grid_width_d;
      grid_length_q <= grid_length_d;
    end
  end

  // intake: bounds and limit checks, cell index
  gbs_front #(
    .MAX_GRID_X (MAX_GRID_X),
    .MAX_GRID_Y (MAX_GRID_Y),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_front (
    .start_i       (start),
    .q_full_i      (q_full),
    .clearing_i    (clearing),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .capacity_in_i (capacity_in_i),
    .item_in_i     (item_in_i),
    .floor_limit_i (floor_limit_q),
    .grid_width_i  (grid_width_q),
    .grid_length_i (grid_length_q),
    .busy_o        (busy),
    .push_o        (q_push),
    .op_o          (op_in)
  );

  // decouples intake from execution
  gbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (op_in),
    .pop_i   (q_pop),
    .head_o  (op_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // execution: cell table, stack memory, result registers
  gbs_back #(
    .MAX_GRID_X (MAX_GRID_X),
    .MAX_GRID_Y (MAX_GRID_Y),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (op_head),
    .pop_o         (q_pop),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .status_o      (status_o),
    .item_out_o    (item_out_o),
    .stack_count_o (stack_count_o),
    .error_flags_o (error_flags_o)
  );

endmodule

/* rtl/gbs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_front: command intake and classification
// Takes a command beat, checks capacity limit and grid bounds, and forms the
// queue record with the flat cell index.
// ----------------------------------------------------------------------------
module gbs_front #(
  parameter int MAX_GRID_X = gbs_pkg::MaxGridXDef,
  parameter int MAX_GRID_Y = gbs_pkg::MaxGridYDef,
  parameter int MAX_DEPTH  = gbs_pkg::MaxDepthDef
) (
  input  logic                          start_i,
  input  logic                          q_full_i,
  input  logic                          clearing_i,
  input  logic [gbs_pkg::ActionW-1:0]   action_i,
  input  logic [gbs_pkg::PosW-1:0]      pos_x_i,
  input  logic [gbs_pkg::PosW-1:0]      pos_y_i,
  input  logic [gbs_pkg::CapInW-1:0]    capacity_in_i,
  input  logic [gbs_pkg::ItemW-1:0]     item_in_i,
  input  logic [gbs_pkg::CfgDataW-1:0]  floor_limit_i,
  input  logic [gbs_pkg::CfgDataW-1:0]  grid_width_i,
  input  logic [gbs_pkg::CfgDataW-1:0]  grid_length_i,
  output logic                          busy_o,
  output logic                          push_o,
  output gbs_pkg::op_t                  op_o
);

  logic cap_high;
  logic outside;

  assign busy_o = clearing_i | q_full_i;
  assign push_o = start_i & ~busy_o;

  assign cap_high = (capacity_in_i >= floor_limit_i) ||
                    (32'(capacity_in_i) >= 32'(MAX_DEPTH));
  assign outside  = (pos_x_i >= grid_width_i)  || (32'(pos_x_i) >= 32'(MAX_GRID_X)) ||
                    (pos_y_i >= grid_length_i) || (32'(pos_y_i) >= 32'(MAX_GRID_Y));

  always_comb begin
    op_o.cell_ix = gbs_pkg::CellIdxMaxW'(32'(pos_y_i) * 32'(MAX_GRID_X) + 32'(pos_x_i));
    op_o.cap     = capacity_in_i;
    op_o.item    = item_in_i;
    case (action_i)
      gbs_pkg::ActSetCap: begin
        if (cap_high) begin
          op_o.kind = gbs_pkg::KdCapHigh;
        end else if (outside) begin
          op_o.kind = gbs_pkg::KdOutSet;
        end else begin
          op_o.kind = gbs_pkg::KdSet;
        end
      end
      gbs_pkg::ActPush: op_o.kind = outside ? gbs_pkg::KdOutAccess : gbs_pkg::KdPush;
      gbs_pkg::ActPop:  op_o.kind = outside ? gbs_pkg::KdOutAccess : gbs_pkg::KdPop;
      default:          op_o.kind = gbs_pkg::KdNop;
    endcase
  end

endmodule

/* rtl/gbs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_queue: command queue
// Short first-in first-out buffer between intake and execution.
// ----------------------------------------------------------------------------
module gbs_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  gbs_pkg::op_t data_i,
  input  logic         pop_i,
  output gbs_pkg::op_t head_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int Depth = gbs_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  gbs_pkg::op_t    entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign head_o  = entry_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/gbs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_back: command execution
// Clears the cell table after reset, then runs each queued command as a
// read-modify-write of the cell table and the stack memory.
// ----------------------------------------------------------------------------
module gbs_back #(
  parameter int MAX_GRID_X = gbs_pkg::MaxGridXDef,
  parameter int MAX_GRID_Y = gbs_pkg::MaxGridYDef,
  parameter int MAX_DEPTH  = gbs_pkg::MaxDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  gbs_pkg::op_t                   head_i,
  output logic                           pop_o,
  output logic                           clearing_o,
  output logic                           done_o,
  output logic [gbs_pkg::StatusW-1:0]    status_o,
  output logic [gbs_pkg::ItemW-1:0]      item_out_o,
  output logic [gbs_pkg::CountOutW-1:0]  stack_count_o,
  output logic [gbs_pkg::FlagW-1:0]      error_flags_o
);

  localparam int Cells      = MAX_GRID_X * MAX_GRID_Y;
  localparam int CellW      = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int CapMax     = (MAX_DEPTH - 1 < 30) ? MAX_DEPTH - 1 : 30;
  localparam int CapW       = $clog2(CapMax + 1);
  localparam int SlotW      = (CapMax > 1) ? $clog2(CapMax) : 1;
  localparam int StackDepth = Cells * (1 << SlotW);
  localparam int StackAw    = CellW + SlotW;
  localparam int WordW      = 2 * CapW;

  gbs_pkg::back_state_e state_q, state_d;

  logic [WordW-1:0]           cell_mem [Cells];
  logic [gbs_pkg::ItemW-1:0]  stk_mem  [StackDepth];

  gbs_pkg::op_t               op_q;
  logic [WordW-1:0]           cell_rd_q;
  logic [gbs_pkg::ItemW-1:0]  stk_rd_q;
  logic [CellW-1:0]           clr_ptr_q, clr_ptr_d;
  logic [gbs_pkg::FlagW-1:0]  lerr_q, lerr_d;
  logic                       done_q, done_d;
  logic [gbs_pkg::StatusW-1:0] status_q;
  logic [gbs_pkg::ItemW-1:0]  item_q;
  logic [gbs_pkg::CountOutW-1:0] count_q;

  logic [CellW-1:0]           cell_idx, head_idx, cell_wa;
  logic [CapW-1:0]            cur_cap, cur_cnt, cap_in, res_cnt;
  logic [WordW-1:0]           cell_wd;
  logic                       cell_we, stk_we, stk_re, res_we, item_we;
  logic [StackAw-1:0]         stk_wa, stk_ra;
  logic [gbs_pkg::StatusW-1:0] res_status;

  assign cell_idx = op_q.cell_ix[CellW-1:0];
  assign head_idx = head_i.cell_ix[CellW-1:0];
  assign cur_cap  = cell_rd_q[WordW-1:CapW];
  assign cur_cnt  = cell_rd_q[CapW-1:0];
  assign cap_in   = op_q.cap[CapW-1:0];

  always_comb begin
    state_d    = state_q;
    clr_ptr_d  = clr_ptr_q;
    lerr_d     = lerr_q;
    done_d     = 1'b0;
    pop_o      = 1'b0;
    cell_we    = 1'b0;
    cell_wa    = clr_ptr_q;
    cell_wd    = '0;
    stk_we     = 1'b0;
    stk_wa     = {cell_idx, SlotW'(cur_cnt)};
    stk_re     = 1'b0;
    stk_ra     = {cell_idx, SlotW'(cur_cnt - 1'b1)};
    res_we     = 1'b0;
    res_status = gbs_pkg::StOk;
    res_cnt    = '0;
    item_we    = 1'b0;
    case (state_q)
      gbs_pkg::BkClear: begin
        cell_we = 1'b1;
        if (clr_ptr_q == CellW'(Cells - 1)) begin
          state_d = gbs_pkg::BkFetch;
        end else begin
          clr_ptr_d = CellW'(clr_ptr_q + 1'b1);
        end
      end
      gbs_pkg::BkFetch: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = gbs_pkg::BkEval;
        end
      end
      gbs_pkg::BkEval: begin
        state_d = gbs_pkg::BkFetch;
        res_we  = 1'b1;
        done_d  = 1'b1;
        cell_wa = cell_idx;
        case (op_q.kind)
          gbs_pkg::KdCapHigh: begin
            res_status = gbs_pkg::StCapHigh;
            lerr_d     = lerr_q | gbs_pkg::ErrCapOver;
          end
          gbs_pkg::KdOutSet: begin
            res_status = gbs_pkg::StOutside;
            lerr_d     = lerr_q | gbs_pkg::ErrGrid;
          end
          gbs_pkg::KdOutAccess: begin
            res_status = gbs_pkg::StOutside;
          end
          gbs_pkg::KdSet: begin
            res_cnt = cur_cnt;
            if (cur_cap != '0) begin
              if (cur_cap == cap_in) begin
                res_status = gbs_pkg::StRepSame;
                lerr_d     = lerr_q | gbs_pkg::ErrBadFormat;
              end else begin
                res_status = gbs_pkg::StRepDiff;
                lerr_d     = lerr_q | gbs_pkg::ErrGrid;
              end
            end else begin
              // a zero capacity is stored too and leaves the cell unset
              cell_we = 1'b1;
              cell_wd = {cap_in, cur_cnt};
            end
          end
          gbs_pkg::KdPush: begin
            if (cur_cnt >= cur_cap) begin
              res_status = gbs_pkg::StFull;
              res_cnt    = cur_cnt;
            end else begin
              stk_we  = 1'b1;
              cell_we = 1'b1;
              res_cnt = CapW'(cur_cnt + 1'b1);
              cell_wd = {cur_cap, res_cnt};
            end
          end
          gbs_pkg::KdPop: begin
            if (cur_cnt == '0) begin
              res_status = gbs_pkg::StEmpty;
            end else begin
              // top word comes out of the stack memory next cycle
              stk_re  = 1'b1;
              cell_we = 1'b1;
              res_cnt = CapW'(cur_cnt - 1'b1);
              cell_wd = {cur_cap, res_cnt};
              done_d  = 1'b0;
              state_d = gbs_pkg::BkPop;
            end
          end
          default: begin
            res_status = gbs_pkg::StOk;
          end
        endcase
      end
      gbs_pkg::BkPop: begin
        item_we = 1'b1;
        done_d  = 1'b1;
        state_d = gbs_pkg::BkFetch;
      end
      default: begin
        state_d = gbs_pkg::BkFetch;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gbs_pkg::BkClear;
      clr_ptr_q <= '0;
      lerr_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      lerr_q    <= lerr_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q      <= head_i;
      cell_rd_q <= cell_mem[head_idx];
    end
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    if (stk_we) begin
      stk_mem[stk_wa] <= op_q.item;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
    if (res_we) begin
      status_q <= res_status;
      count_q  <= gbs_pkg::CountOutW'(res_cnt);
      item_q   <= '0;
    end
    if (item_we) begin
      item_q <= stk_rd_q;
    end
  end

  assign clearing_o    = (state_q == gbs_pkg::BkClear);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign item_out_o    = item_q;
  assign stack_count_o = count_q;
  assign error_flags_o = lerr_q;

endmodule

/* rtl/gbs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_checker: port-level checks of the bounded stack grid
// Watches the result beats and the sticky error flags.
// ----------------------------------------------------------------------------
module gbs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           done_o,
  input logic [gbs_pkg::StatusW-1:0]    status_o,
  input logic [gbs_pkg::ItemW-1:0]      item_out_o,
  input logic [gbs_pkg::CountOutW-1:0]  stack_count_o,
  input logic [gbs_pkg::FlagW-1:0]      error_flags_o
);

  // a command passes through the fetch and evaluate states, so result beats never come back to back
  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beats in consecutive cycles");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= gbs_pkg::StEmpty))
    else $error("unknown status code");

  a_item_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != gbs_pkg::StOk)) |-> (item_out_o == '0))
    else $error("item word on a refused command");

  a_outside_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == gbs_pkg::StOutside)) |-> (stack_count_o == '0))
    else $error("count reported for a cell outside the grid");

  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((error_flags_o & $past(error_flags_o)) == $past(error_flags_o)))
    else $error("sticky error flag cleared");

endmodule

bind grid_of_bounded_stacks gbs_checker u_gbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .done_o        (done_o),
  .status_o      (status_o),
  .item_out_o    (item_out_o),
  .stack_count_o (stack_count_o),
  .error_flags_o (error_flags_o)
);
